// ===== src/tar_pkg.sv =====
// Shared types and constants for the tour adjacency rebuild block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tar_pkg;

  localparam int unsigned POINT_W        = 10;
  localparam int unsigned SLOT_W         = POINT_W + 1;
  localparam int unsigned LEN_W          = 11;
  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned MAX_POINTS_DEF = 1024;

  // Slot value that names no point.
  localparam logic [SLOT_W-1:0] NO_POINT = SLOT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_BREAK   = 2'd0,
    OP_CREATE  = 2'd1,
    OP_REBUILD = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [POINT_W-1:0] point_a;
    logic [POINT_W-1:0] point_b;
  } in_item_t;

  typedef struct packed {
    logic [POINT_W-1:0] successor;
    logic               status;
    logic [LEN_W-1:0]   tour_length;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] s1;
    logic [SLOT_W-1:0] s0;
  } slot_pair_t;

  localparam slot_pair_t EMPTY_PAIR = '{s1: NO_POINT, s0: NO_POINT};

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_EDGE_A   = 8'b0000_0100,
    S_EDGE_RDB = 8'b0000_1000,
    S_EDGE_B   = 8'b0001_0000,
    S_READ     = 8'b0010_0000,
    S_WALK     = 8'b0100_0000,
    S_POST     = 8'b1000_0000
  } state_t;

endpackage

// ===== src/tar_slot_alu.sv =====
// Shared slot unit: clear/fill update of one neighbour pair and the
// "other neighbour" pick used by the walk. Depends on tar_pkg.
`timescale 1ns / 1ps

module tar_slot_alu
  import tar_pkg::*;
(
  input  op_t                mode,
  input  slot_pair_t         word,
  input  logic [POINT_W-1:0] peer,
  output slot_pair_t         new_word,
  output logic [SLOT_W-1:0]  other
);

  logic [SLOT_W-1:0] peer_slot;
  logic              hit0;
  logic              hit1;

  assign peer_slot = {1'b0, peer};
  assign hit0      = (word.s0 == peer_slot);
  assign hit1      = (word.s1 == peer_slot);

  // Walk: take the slot that does not lead back, slot 1 on a tie.
  assign other = hit0 ? word.s1 : word.s0;

  always_comb begin
    new_word = word;
    if (mode == OP_BREAK) begin
      if (hit0) new_word.s0 = NO_POINT;
      if (hit1) new_word.s1 = NO_POINT;
    end else begin
      if (word.s0 == NO_POINT) begin
        new_word.s0 = peer_slot;
      end else if (word.s1 == NO_POINT) begin
        new_word.s1 = peer_slot;
      end
    end
  end

endmodule

// ===== src/tour_adjacency_rebuild_core.sv =====
// Top level of the tour adjacency rebuild block: sequencer, neighbour table,
// successor table and result register. Depends on tar_pkg, tar_slot_alu.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) carries one op per transaction:
//   break edge, create edge, rebuild successors or read successor. Result
//   channel (out_valid/out_ready/out_data) returns exactly one transaction per
//   op. The block works on one op at a time; in_ready is high only when idle.
//   Break / create do two read-modify-writes through one port; read successor
//   does one registered successor-table read; rebuild makes one
//   neighbour-table read per visited point, which sets its pace.
//   in_ready returns on the same edge that raises out_valid.
//   Reset: rst_n is synchronous. After it, a clearing pass writes the empty
//   mark into all 1024 neighbour entries, one per cycle, with in_ready low
//   throughout. The successor table is not cleared.
//   Stall: a result waits in the output register while out_ready is low; the
//   sequencer holds its finished result until that register frees up.
`timescale 1ns / 1ps

module tour_adjacency_rebuild_core
  import tar_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Walk limit: smaller of MAX_POINTS and the table depth.
  localparam int unsigned      WALK_LIMIT = (MAX_POINTS < TABLE_DEPTH) ? MAX_POINTS : TABLE_DEPTH;
  localparam logic [LEN_W-1:0] LIMIT_L    = LEN_W'(WALK_LIMIT);

  state_t             state_r, state_nxt;
  logic [POINT_W-1:0] clr_r, clr_nxt;
  op_t                op_r, op_nxt;
  logic [POINT_W-1:0] a_r, a_nxt;
  logic [POINT_W-1:0] b_r, b_nxt;
  logic [POINT_W-1:0] cur_r, cur_nxt;
  logic [POINT_W-1:0] prev_r, prev_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               first_r, first_nxt;
  logic [LEN_W-1:0]   last_len_r, last_len_nxt;
  logic [POINT_W-1:0] res_succ_r, res_succ_nxt;
  logic               res_status_r, res_status_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Neighbour table: one write, one registered read per cycle.
  slot_pair_t         slot_mem [TABLE_DEPTH];
  slot_pair_t         slot_rdata_r;
  logic               slot_we;
  logic [POINT_W-1:0] slot_waddr;
  slot_pair_t         slot_wdata;
  logic [POINT_W-1:0] slot_raddr;

  // Successor table.
  logic [POINT_W-1:0] succ_mem [TABLE_DEPTH];
  logic [POINT_W-1:0] succ_rdata_r;
  logic               succ_we;

  // Shared slot unit.
  logic [POINT_W-1:0] alu_peer;
  slot_pair_t         alu_word;
  logic [SLOT_W-1:0]  alu_other;
  logic [SLOT_W-1:0]  walk_next;
  logic               slot_free;

  tar_slot_alu u_alu (
    .mode     (op_r),
    .word     (slot_rdata_r),
    .peer     (alu_peer),
    .new_word (alu_word),
    .other    (alu_other)
  );

  always_comb begin
    unique case (state_r)
      S_EDGE_B: alu_peer = a_r;
      S_WALK:   alu_peer = prev_r;
      default:  alu_peer = b_r;
    endcase
  end

  // First step of a walk takes slot 0 of point 0 as is.
  assign walk_next = first_r ? slot_rdata_r.s0 : alu_other;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (state_r)
      S_IDLE:     slot_raddr = (in_data.op == OP_REBUILD) ? '0 : in_data.point_a;
      S_EDGE_RDB: slot_raddr = b_r;
      S_WALK:     slot_raddr = walk_next[POINT_W-1:0];
      default:    slot_raddr = a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[cur_r] <= walk_next[POINT_W-1:0];
    end
    succ_rdata_r <= succ_mem[in_data.point_a];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    last_len_nxt   = last_len_r;
    res_succ_nxt   = res_succ_r;
    res_status_nxt = res_status_r;
    slot_we        = 1'b0;
    slot_waddr     = a_r;
    slot_wdata     = alu_word;
    succ_we        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = EMPTY_PAIR;
        clr_nxt    = clr_r + POINT_W'(1);
        if (clr_r == {POINT_W{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          a_nxt          = in_data.point_a;
          b_nxt          = in_data.point_b;
          res_succ_nxt   = '0;
          res_status_nxt = 1'b0;
          unique case (in_data.op) inside
            OP_BREAK, OP_CREATE: state_nxt = S_EDGE_A;
            OP_REBUILD: begin
              cur_nxt   = '0;
              cnt_nxt   = LEN_W'(1);
              first_nxt = 1'b1;
              state_nxt = S_WALK;
            end
            OP_READ:    state_nxt = S_READ;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_EDGE_A: begin
        slot_we    = 1'b1;
        slot_waddr = a_r;
        state_nxt  = S_EDGE_RDB;
      end
      S_EDGE_RDB: state_nxt = S_EDGE_B;
      S_EDGE_B: begin
        slot_we    = 1'b1;
        slot_waddr = b_r;
        state_nxt  = S_POST;
      end
      S_READ: begin
        res_succ_nxt = succ_rdata_r;
        state_nxt    = S_POST;
      end
      S_WALK: begin
        if (walk_next == NO_POINT) begin
          // dead end: nothing written for this point
          last_len_nxt   = cnt_r;
          res_status_nxt = 1'b1;
          state_nxt      = S_POST;
        end else begin
          succ_we = 1'b1;
          if (walk_next[POINT_W-1:0] == '0) begin
            last_len_nxt = cnt_r;
            state_nxt    = S_POST;
          end else if (cnt_r >= LIMIT_L) begin
            last_len_nxt   = LIMIT_L;
            res_status_nxt = 1'b1;
            state_nxt      = S_POST;
          end else begin
            cnt_nxt   = cnt_r + LEN_W'(1);
            prev_nxt  = cur_r;
            cur_nxt   = walk_next[POINT_W-1:0];
            first_nxt = 1'b0;
          end
        end
      end
      S_POST: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      last_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      last_len_r   <= last_len_nxt;
      if (state_r == S_POST && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    cnt_r        <= cnt_nxt;
    first_r      <= first_nxt;
    res_succ_r   <= res_succ_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_POST && slot_free) begin
      out_data_r.successor   <= res_succ_r;
      out_data_r.status      <= res_status_r;
      out_data_r.tour_length <= last_len_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/tar_checker.sv =====
// Port-level checker for tour_adjacency_rebuild_core, with its bind.
// Depends on tar_pkg.
`timescale 1ns / 1ps

module tar_checker
  import tar_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Clearing pass follows every reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // One transaction in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Error status only comes from rebuild, which reports successor zero.
  a_err_no_succ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.successor == '0)
    else $error("error result with nonzero successor");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.tour_length <= LEN_W'(TABLE_DEPTH))
    else $error("tour length beyond table depth");

endmodule

bind tour_adjacency_rebuild_core tar_checker u_tar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/tar_tour_checker.sv =====
// Checker for tour_adjacency_rebuild_core: watches both channels, predicts each
// result from its own neighbour and successor tables, and compares field by field.
// Depends on tar_pkg.
`timescale 1ns / 1ps

module tar_tour_checker
  import tar_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  output int                     fail_count,
  output int                     pending,
  output logic [TABLE_DEPTH-1:0] succ_known
);

  localparam int unsigned WALK_LIMIT =
    (MAX_POINTS < TABLE_DEPTH) ? MAX_POINTS : TABLE_DEPTH;

  slot_pair_t             nbr_tab [TABLE_DEPTH];
  logic [POINT_W-1:0]     succ_tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written;
  logic [LEN_W-1:0]       walk_len;
  out_item_t              due_q [$];
  int                     fails;

  function automatic void fill_slot(logic [POINT_W-1:0] p, logic [POINT_W-1:0] q);
    if (nbr_tab[p].s0 == NO_POINT) begin
      nbr_tab[p].s0 = {1'b0, q};
    end else if (nbr_tab[p].s1 == NO_POINT) begin
      nbr_tab[p].s1 = {1'b0, q};
    end
  endfunction

  function automatic void drop_slot(logic [POINT_W-1:0] p, logic [POINT_W-1:0] q);
    if (nbr_tab[p].s0 == {1'b0, q}) begin
      nbr_tab[p].s0 = NO_POINT;
    end
    if (nbr_tab[p].s1 == {1'b0, q}) begin
      nbr_tab[p].s1 = NO_POINT;
    end
  endfunction

  // Walk from point 0; returns 1 on an empty slot or when the point limit is hit.
  function automatic logic walk_tour();
    int unsigned        steps;
    logic [POINT_W-1:0] here;
    logic [POINT_W-1:0] came_from;
    logic [SLOT_W-1:0]  nxt;
    steps = 1;
    here  = '0;
    nxt   = nbr_tab[0].s0;
    if (nxt == NO_POINT) begin
      walk_len = LEN_W'(steps);
      return 1'b1;
    end
    succ_tab[0] = nxt[POINT_W-1:0];
    written[0]  = 1'b1;
    while (1'b1) begin
      came_from = here;
      here      = succ_tab[here];
      if (here == '0) begin
        break;
      end
      if (steps >= WALK_LIMIT) begin
        walk_len = LEN_W'(WALK_LIMIT);
        return 1'b1;
      end
      steps++;
      nxt = (nbr_tab[here].s0 == {1'b0, came_from}) ? nbr_tab[here].s1 : nbr_tab[here].s0;
      if (nxt == NO_POINT) begin
        walk_len = LEN_W'(steps);
        return 1'b1;
      end
      succ_tab[here] = nxt[POINT_W-1:0];
      written[here]  = 1'b1;
    end
    walk_len = LEN_W'(steps);
    return 1'b0;
  endfunction

  function automatic out_item_t apply_op(in_item_t it);
    out_item_t res;
    res = '0;
    case (it.op)
      OP_BREAK: begin
        drop_slot(it.point_a, it.point_b);
        drop_slot(it.point_b, it.point_a);
      end
      OP_CREATE: begin
        fill_slot(it.point_a, it.point_b);
        fill_slot(it.point_b, it.point_a);
      end
      OP_REBUILD: begin
        res.status = walk_tour();
      end
      OP_READ: begin
        res.successor = written[it.point_a] ? succ_tab[it.point_a] : '0;
      end
      default: begin
      end
    endcase
    res.tour_length = walk_len;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        nbr_tab[i] = EMPTY_PAIR;
      end
      written  = '0;
      walk_len = '0;
      fails    = 0;
      due_q.delete();
      fail_count <= 0;
      pending    <= 0;
      succ_known <= '0;
    end else begin
      if (in_valid && in_ready) begin
        due_q.insert(due_q.size(), apply_op(in_data));
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (out_data.successor !== want.successor) begin
            $error("successor: expected %0d, got %0d", want.successor, out_data.successor);
            fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.tour_length !== want.tour_length) begin
            $error("tour_length: expected %0d, got %0d", want.tour_length,
                   out_data.tour_length);
            fails++;
          end
        end
      end
      fail_count <= fails;
      pending    <= due_q.size();
      succ_known <= written;
    end
  end

endmodule

// ===== tb/tb_tour_adjacency_rebuild_core.sv =====
// Testbench top for tour_adjacency_rebuild_core: stimulus, result-side stalls,
// watchdog and verdict. Depends on tar_pkg, tar_tour_checker and the block.
`timescale 1ns / 1ps

module tb_tour_adjacency_rebuild_core
  import tar_pkg::*;
();

  localparam int ITEM_TARGET = 1050;
  // Set well above the slowest sane run (long gaps, long stalls, one
  // limit walk, the clearing pass).
  localparam int CYCLE_LIMIT = 1500000;
  // Settle time after the last result has drained.
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [POINT_W-1:0] a;
    logic [POINT_W-1:0] b;
  } link_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int                     fail_count;
  int                     pending;
  logic [TABLE_DEPTH-1:0] succ_known;

  int    sent = 0;
  int    cycles = 0;
  bit    quiet = 1'b0;          // episode with no sender gaps
  int    ring [$];              // current tour in visiting order, ring[0] == 0
  link_t junk_q [$];            // stray creates to undo at episode end

  tour_adjacency_rebuild_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tar_tour_checker tour_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .succ_known (succ_known)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: alternating runs of ready and stall. Stalls are mostly
  // short with the odd long one; some ready runs are long so that stretches
  // with no back-pressure occur too.
  initial begin : ready_gen
    int   run;
    logic level;
    run   = 0;
    level = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        level = !level;
        if (level) begin
          run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 20);
        end else begin
          case ($urandom_range(0, 19))
            0:       run = $urandom_range(20, 60);
            1, 2, 3: run = $urandom_range(4, 12);
            default: run = $urandom_range(1, 3);
          endcase
        end
      end
      out_ready <= level;
      run--;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Any point whose successor some rebuild has written. The map from the
  // checker may lag by one transaction; it only ever grows, so a hit is safe.
  function automatic int pick_read_point();
    int start;
    int idx;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      idx = (start + i) % TABLE_DEPTH;
      if (succ_known[idx]) begin
        return idx;
      end
    end
    return -1;
  endfunction

  // One transaction. Called at a clock edge; returns at the edge that accepts
  // it, with in_valid still high so a back-to-back item need not raise it again.
  task automatic send_op(input op_t op, input int a, input int b);
    in_item_t item;
    int       gap;
    item.op      = op;
    item.point_a = POINT_W'(a);
    item.point_b = POINT_W'(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sent++;
  endtask

  task automatic link(input int a, input int b);
    if ($urandom_range(0, 1)) begin
      send_op(OP_CREATE, a, b);
    end else begin
      send_op(OP_CREATE, b, a);
    end
  endtask

  task automatic cut(input int a, input int b);
    if ($urandom_range(0, 1)) begin
      send_op(OP_BREAK, a, b);
    end else begin
      send_op(OP_BREAK, b, a);
    end
  endtask

  // Read a chosen point if its successor is known, else any known one.
  // With nothing known yet a rebuild goes out instead.
  task automatic read_point(input int want);
    int p;
    p = (want >= 0 && succ_known[want]) ? want : pick_read_point();
    if (p < 0) begin
      send_op(OP_REBUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end else begin
      send_op(OP_READ, p, $urandom_range(0, 1023));
    end
  endtask

  // Hold off the sender until every expected result is back. The extra edge
  // lets the checker count the transaction accepted at the current edge.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Stray transaction: random op and points. Creates are remembered so the
  // episode teardown can break them again and leave the table clean.
  task automatic maybe_noise();
    int    a;
    int    b;
    op_t   op;
    link_t stray;
    if ($urandom_range(0, 9) != 0) begin
      return;
    end
    a  = $urandom_range(0, 1023);
    b  = $urandom_range(0, 1023);
    op = op_t'($urandom_range(0, 3));
    case (op)
      OP_READ: begin
        read_point(-1);
      end
      OP_CREATE: begin
        stray.a = POINT_W'(a);
        stray.b = POINT_W'(b);
        junk_q.insert(junk_q.size(), stray);
        send_op(OP_CREATE, a, b);
      end
      default: begin
        send_op(op, a, b);
      end
    endcase
  endtask

  task automatic read_some(input int n);
    repeat (n) begin
      if ($urandom_range(0, 1) && ring.size() > 0) begin
        read_point(ring[$urandom_range(0, ring.size() - 1)]);
      end else begin
        read_point(-1);
      end
    end
  endtask

  // Directed corner cases.
  task automatic run_directed();
    // empty table: point 0 has no neighbour
    send_op(OP_REBUILD, 0, 0);
    // double link between 5 and 6 fills both of their slots; 0 then sees 5
    // but 5 has no room for 0, so the walk bounces 5-6 until the point limit
    send_op(OP_CREATE, 5, 6);
    send_op(OP_CREATE, 6, 5);
    send_op(OP_CREATE, 0, 5);
    send_op(OP_REBUILD, 0, 0);
    send_op(OP_BREAK, 5, 6);
    send_op(OP_BREAK, 0, 5);
    // small clean tour over the extreme point numbers and alternating bits
    send_op(OP_CREATE, 0, 1023);
    send_op(OP_CREATE, 1023, 341);
    send_op(OP_CREATE, 682, 341);
    send_op(OP_CREATE, 682, 0);
    send_op(OP_REBUILD, 1023, 1023);
    wait_results();
    read_point(0);
    read_point(1023);
    read_point(341);
    read_point(682);
    // open the tour: the walk dies at an empty slot part way round
    send_op(OP_BREAK, 682, 341);
    send_op(OP_REBUILD, 0, 0);
    // self edge on 341 turns the walk back toward 0
    send_op(OP_CREATE, 341, 341);
    send_op(OP_REBUILD, 0, 0);
    send_op(OP_BREAK, 341, 341);
    send_op(OP_BREAK, 1023, 0);
    send_op(OP_BREAK, 341, 1023);
    send_op(OP_BREAK, 0, 682);
  endtask

  // One episode: load a random tour through point 0, rebuild, apply a few
  // 2-opt moves with rebuilds and reads in between, then tear it all down.
  task automatic run_tour_episode();
    int                     k;
    int                     p;
    int                     i;
    int                     j;
    int                     lo;
    int                     hi;
    int                     tmp;
    int                     moves;
    int                     order [$];
    logic [TABLE_DEPTH-1:0] used;
    // mostly small tours, now and then a long one
    k = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 16);
    quiet = ($urandom_range(0, 3) == 0);
    ring.delete();
    used    = '0;
    used[0] = 1'b1;
    ring.insert(ring.size(), 0);
    while (ring.size() < k) begin
      p = $urandom_range(1, 1023);
      if (!used[p]) begin
        used[p] = 1'b1;
        ring.insert(ring.size(), p);
      end
    end
    // load the edges in shuffled order
    for (int e = 0; e < k; e++) begin
      order.insert(order.size(), e);
    end
    for (int e = k - 1; e > 0; e--) begin
      j        = $urandom_range(0, e);
      tmp      = order[e];
      order[e] = order[j];
      order[j] = tmp;
    end
    foreach (order[e]) begin
      link(ring[order[e]], ring[(order[e] + 1) % k]);
      maybe_noise();
    end
    send_op(OP_REBUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
    read_some($urandom_range(1, 3));

    moves = (k >= 4) ? $urandom_range(0, 4) : 0;
    repeat (moves) begin
      // edges (ring[i], ring[i+1]) and (ring[j], ring[j+1]) must not touch
      i = $urandom_range(0, k - 3);
      j = $urandom_range(i + 2, (i == 0) ? k - 2 : k - 1);
      cut(ring[i], ring[i + 1]);
      cut(ring[j], ring[(j + 1) % k]);
      if ($urandom_range(0, 6) == 0) begin
        // walk while the tour is open
        send_op(OP_REBUILD, 0, 0);
      end
      link(ring[i], ring[j]);
      link(ring[i + 1], ring[(j + 1) % k]);
      maybe_noise();
      lo = i + 1;
      hi = j;
      while (lo < hi) begin
        tmp      = ring[lo];
        ring[lo] = ring[hi];
        ring[hi] = tmp;
        lo++;
        hi--;
      end
      if ($urandom_range(0, 9) < 7) begin
        send_op(OP_REBUILD, 0, 0);
      end
      read_some($urandom_range(0, 2));
    end

    if ($urandom_range(0, 9) < 3) begin
      send_op(OP_REBUILD, 0, 0);
    end
    for (int e = 0; e < k; e++) begin
      cut(ring[e], ring[(e + 1) % k]);
    end
    foreach (junk_q[e]) begin
      send_op(OP_BREAK, junk_q[e].a, junk_q[e].b);
    end
    junk_q.delete();
    ring.delete();
    if ($urandom_range(0, 3) == 0) begin
      wait_results();
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // in_ready stays low through the clearing pass; send_op waits it out
    run_directed();
    while (sent < ITEM_TARGET) begin
      run_tour_episode();
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tar_pkg.sv
src/tar_slot_alu.sv
src/tour_adjacency_rebuild_core.sv
src/tar_checker.sv
tb/tar_tour_checker.sv
tb/tb_tour_adjacency_rebuild_core.sv
